@@ rtl/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg
// Types, sizes and codes shared by the priority scheduler and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

	// task table size and derived widths
	localparam int MAX_TASKS = 32;
	localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);
	localparam int ID_W      = 6;

	// operation codes of an input word
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_LOAD_OK  = 2'd0;
	localparam logic [1:0] KIND_LOAD_REJ = 2'd1;
	localparam logic [1:0] KIND_IDLE     = 2'd2;
	localparam logic [1:0] KIND_RAN      = 2'd3;

	// input word
	typedef struct packed {
		logic        op;
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [7:0]  prio;
	} req_t;

	// result word
	typedef struct packed {
		logic [1:0]      kind;
		logic [ID_W-1:0] task_id;
		logic [31:0]     time_end;
		logic            finished;
		logic [31:0]     turnaround;
		logic [31:0]     waiting;
		logic [31:0]     sum_waiting;
		logic [31:0]     sum_turnaround;
		logic            all_done;
	} rsp_t;

	// one entry of the task table
	typedef struct packed {
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [7:0]  prio;
		logic [15:0] left;
	} task_rec_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_UPDATE,
		ST_RESP
	} state_t;

endpackage

`default_nettype wire

@@ rtl/pps_if.sv @@
// ----------------------------------------------------------------------------
// pps_req_if / pps_rsp_if
// Valid/ready channels carrying scheduler input words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface pps_req_if;
	import pps_pkg::*;
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pps_rsp_if;
	import pps_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/preemptive_priority_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_top
// Task table with a one-unit-per-tick preemptive priority scheduler.
// ----------------------------------------------------------------------------
// A load word goes from the idle state to the response state. A tick word
// scans the task table one entry per cycle through the single read port of
// the table memory, then passes the drain and update states on its way to
// the response state; a tick on an empty table goes straight there. One word
// is in work at a time; the result register lets the next word in while a
// result waits to be taken. The table needs no clearing pass after reset:
// only entries below the task count are ever used.
`default_nettype none

module preemptive_priority_scheduler_top
	import pps_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	pps_req_if.sink       req,
	pps_rsp_if.source     rsp
);

	// state registers
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  task_count_q;
	logic [CNT_W-1:0]  done_count_q;
	logic [31:0]       clock_q;
	logic [31:0]       total_wait_q;
	logic [31:0]       total_turn_q;

	// scan control and best candidate
	logic [IDX_W-1:0]  scan_q;
	logic              found_q;
	logic [IDX_W-1:0]  best_idx_q;
	task_rec_t         best_q;

	// memory read stage
	task_rec_t         rd_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              vld_s1;

	// pending result fields
	logic [1:0]        kind_q;
	logic [ID_W-1:0]   id_q;
	logic              fin_q;
	logic [31:0]       turn_q;
	logic [31:0]       wait_q;

	// result register
	logic              out_valid_q;
	rsp_t              out_q;

	// task table
	task_rec_t         mem [MAX_TASKS];

	// combinational control
	logic              accept;
	logic              load_ok;
	logic              scan_last;
	logic              rsp_free;
	logic              mem_we;
	logic [IDX_W-1:0]  wr_idx;
	task_rec_t         wr_rec;
	logic              cand_ready;
	logic              cand_better;
	logic [15:0]       left_new;
	logic [31:0]       clock_inc;
	logic [31:0]       turn_new;
	logic [31:0]       wait_new;

	assign accept    = req.valid && req.ready;
	assign load_ok   = (task_count_q != CNT_W'(MAX_TASKS)) && (req.data.burst != 16'd0);
	assign scan_last = (CNT_W'(scan_q) + CNT_W'(1)) == task_count_q;
	assign rsp_free  = !out_valid_q || rsp.ready;
	assign left_new  = best_q.left - 16'd1;
	assign clock_inc = clock_q + 32'd1;
	assign turn_new  = clock_inc - {16'd0, best_q.arrival};
	assign wait_new  = turn_new - {16'd0, best_q.burst};

	// candidate compare on the word read last cycle
	assign cand_ready  = ({16'd0, rd_s1.arrival} <= clock_q) && (rd_s1.left != 16'd0);
	assign cand_better = !found_q || (rd_s1.prio > best_q.prio) ||
		((rd_s1.prio == best_q.prio) && (rd_s1.arrival < best_q.arrival));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.data.op == OP_TICK && task_count_q != '0) state_d = ST_SCAN;
					else state_d = ST_RESP;
				end
			end
			ST_SCAN: begin
				if (scan_last) state_d = ST_DRAIN;
			end
			ST_DRAIN:  state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_RESP;
			ST_RESP: begin
				if (rsp_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req.ready = 1'b0;
		mem_we    = 1'b0;
		wr_idx    = best_idx_q;
		wr_rec    = '{arrival: best_q.arrival, burst: best_q.burst,
			prio: best_q.prio, left: left_new};
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				wr_idx    = task_count_q[IDX_W-1:0];
				wr_rec    = '{arrival: req.data.arrival, burst: req.data.burst,
					prio: req.data.prio, left: req.data.burst};
				mem_we    = req.valid && req.data.op == OP_LOAD && load_ok;
			end
			ST_UPDATE: mem_we = found_q;
			default: ;
		endcase
	end

	// table memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_idx] <= wr_rec;
		rd_s1  <= mem[scan_q];
		idx_s1 <= scan_q;
	end

	// sequencer and scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			task_count_q <= '0;
			done_count_q <= '0;
			clock_q      <= '0;
			total_wait_q <= '0;
			total_turn_q <= '0;
			scan_q       <= '0;
			found_q      <= 1'b0;
			vld_s1       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == ST_SCAN);

			// load counts, empty-table clock step, start a scan
			if (state_q == ST_IDLE && accept) begin
				scan_q  <= '0;
				found_q <= 1'b0;
				if (req.data.op == OP_LOAD) begin
					if (load_ok) task_count_q <= task_count_q + CNT_W'(1);
				end else if (task_count_q == '0) begin
					clock_q <= clock_inc;
				end
			end

			if (state_q == ST_SCAN) scan_q <= scan_q + IDX_W'(1);

			// keep the best ready task seen so far
			if (vld_s1 && cand_ready && cand_better) found_q <= 1'b1;

			// one unit of work, completion bookkeeping
			if (state_q == ST_UPDATE) begin
				clock_q <= clock_inc;
				if (found_q && left_new == 16'd0) begin
					done_count_q <= done_count_q + CNT_W'(1);
					total_wait_q <= total_wait_q + wait_new;
					total_turn_q <= total_turn_q + turn_new;
				end
			end

			// result register valid
			if (state_q == ST_RESP && rsp_free) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (vld_s1 && cand_ready && cand_better) begin
			best_q     <= rd_s1;
			best_idx_q <= idx_s1;
		end

		// pending result fields
		if (state_q == ST_IDLE && accept) begin
			fin_q  <= 1'b0;
			turn_q <= '0;
			wait_q <= '0;
			if (req.data.op == OP_LOAD) begin
				if (load_ok) begin
					kind_q <= KIND_LOAD_OK;
					id_q   <= ID_W'(task_count_q + CNT_W'(1));
				end else begin
					kind_q <= KIND_LOAD_REJ;
					id_q   <= '0;
				end
			end else begin
				kind_q <= KIND_IDLE;
				id_q   <= '0;
			end
		end
		if (state_q == ST_UPDATE) begin
			if (found_q) begin
				kind_q <= KIND_RAN;
				id_q   <= ID_W'(CNT_W'(best_idx_q) + CNT_W'(1));
				if (left_new == 16'd0) begin
					fin_q  <= 1'b1;
					turn_q <= turn_new;
					wait_q <= wait_new;
				end
			end else begin
				kind_q <= KIND_IDLE;
			end
		end

		// hand the result to the output register
		if (state_q == ST_RESP && rsp_free) begin
			out_q.kind           <= kind_q;
			out_q.task_id        <= id_q;
			out_q.time_end       <= clock_q;
			out_q.finished       <= fin_q;
			out_q.turnaround     <= turn_q;
			out_q.waiting        <= wait_q;
			out_q.sum_waiting    <= total_wait_q;
			out_q.sum_turnaround <= total_turn_q;
			out_q.all_done       <= (done_count_q == task_count_q);
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// table writes only on a load or a work update
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_IDLE || state_q == ST_UPDATE))
		else $error("table write outside load or update");

	// completed tasks never outnumber loaded tasks
	a_done_count: assert property (@(posedge clk) disable iff (!arst_n)
		done_count_q <= task_count_q)
		else $error("done count above task count");

	// a result only appears after the response state
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_RESP)
		else $error("result valid without response state");

	// the scan reads only loaded entries
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> CNT_W'(scan_q) < task_count_q)
		else $error("scan past loaded entries");

	// a chosen task always has work left
	a_best_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && found_q) |-> best_q.left != 16'd0)
		else $error("chosen task has no work left");

endmodule

`default_nettype wire

@@ tb/pps_checker.sv @@
// ----------------------------------------------------------------------------
// pps_checker
// Watches the input and result channels of the priority scheduler. It keeps
// its own copy of the task table, works out the result word for every
// accepted input word and compares each accepted result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_checker
	import pps_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	pps_req_if        req,
	pps_rsp_if        rsp,
	output int        fails,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// shadow task table and scheduler state
	logic [15:0] tbl_arrival [MAX_TASKS];
	logic [15:0] tbl_burst   [MAX_TASKS];
	logic [7:0]  tbl_prio    [MAX_TASKS];
	logic [15:0] tbl_left    [MAX_TASKS];
	int          n_tasks;
	int          n_done;
	logic [31:0] now_ticks;
	logic [31:0] wait_total;
	logic [31:0] turn_total;

	// result words still owed by the block, oldest first
	rsp_t        owed_results [$];
	int          fail_cnt;
	rsp_t        got_word;
	rsp_t        want_word;
	rsp_t        next_word;

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: result field %s is %0h, %0h predicted", $time, field, got, want);
		fail_cnt++;
	endtask

	// result word built from the current shadow state
	function automatic rsp_t status_word(input logic [1:0] kind, input int id,
			input logic fin, input logic [31:0] turn, input logic [31:0] wt);
		rsp_t r;
		r.kind           = kind;
		r.task_id        = ID_W'(id);
		r.time_end       = now_ticks;
		r.finished       = fin;
		r.turnaround     = turn;
		r.waiting        = wt;
		r.sum_waiting    = wait_total;
		r.sum_turnaround = turn_total;
		r.all_done       = (n_done == n_tasks);
		return r;
	endfunction

	// one load or one tick applied to the shadow state
	task automatic schedule_word(input req_t w, output rsp_t r);
		int          best;
		logic        found;
		logic [31:0] turn;
		logic [31:0] wt;
		best  = 0;
		found = 1'b0;
		if (w.op == OP_LOAD) begin
			if (n_tasks >= MAX_TASKS || w.burst == 16'd0) begin
				r = status_word(KIND_LOAD_REJ, 0, 1'b0, '0, '0);
			end else begin
				tbl_arrival[n_tasks] = w.arrival;
				tbl_burst[n_tasks]   = w.burst;
				tbl_prio[n_tasks]    = w.prio;
				tbl_left[n_tasks]    = w.burst;
				n_tasks++;
				r = status_word(KIND_LOAD_OK, n_tasks, 1'b0, '0, '0);
			end
		end else begin
			// highest priority wins, then earliest arrival, then lowest id
			for (int i = 0; i < n_tasks; i++) begin
				if (32'(tbl_arrival[i]) <= now_ticks && tbl_left[i] != 16'd0) begin
					if (!found || tbl_prio[i] > tbl_prio[best] ||
							(tbl_prio[i] == tbl_prio[best] &&
							tbl_arrival[i] < tbl_arrival[best])) begin
						found = 1'b1;
						best  = i;
					end
				end
			end
			now_ticks = now_ticks + 32'd1;
			if (!found) begin
				r = status_word(KIND_IDLE, 0, 1'b0, '0, '0);
			end else begin
				tbl_left[best] = tbl_left[best] - 16'd1;
				if (tbl_left[best] == 16'd0) begin
					turn = now_ticks - 32'(tbl_arrival[best]);
					wt   = turn - 32'(tbl_burst[best]);
					n_done++;
					wait_total = wait_total + wt;
					turn_total = turn_total + turn;
					r = status_word(KIND_RAN, best + 1, 1'b1, turn, wt);
				end else begin
					r = status_word(KIND_RAN, best + 1, 1'b0, '0, '0);
				end
			end
		end
	endtask

	// results are checked before the same edge's input word is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_tasks    = 0;
			n_done     = 0;
			now_ticks  = '0;
			wait_total = '0;
			turn_total = '0;
			fail_cnt   = 0;
			owed_results.delete();
			fails   <= 0;
			pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got_word = rsp.data;
				if (owed_results.size() == 0) begin
					$display("%0t: result word with none predicted", $time);
					fail_cnt++;
				end else begin
					want_word = owed_results.pop_front();
					if (got_word.kind != want_word.kind)
						report_mismatch("kind", 32'(got_word.kind), 32'(want_word.kind));
					if (got_word.task_id != want_word.task_id)
						report_mismatch("task_id", 32'(got_word.task_id),
							32'(want_word.task_id));
					if (got_word.time_end != want_word.time_end)
						report_mismatch("time_end", got_word.time_end, want_word.time_end);
					if (got_word.finished != want_word.finished)
						report_mismatch("finished", 32'(got_word.finished),
							32'(want_word.finished));
					if (got_word.turnaround != want_word.turnaround)
						report_mismatch("turnaround", got_word.turnaround,
							want_word.turnaround);
					if (got_word.waiting != want_word.waiting)
						report_mismatch("waiting", got_word.waiting, want_word.waiting);
					if (got_word.sum_waiting != want_word.sum_waiting)
						report_mismatch("sum_waiting", got_word.sum_waiting,
							want_word.sum_waiting);
					if (got_word.sum_turnaround != want_word.sum_turnaround)
						report_mismatch("sum_turnaround", got_word.sum_turnaround,
							want_word.sum_turnaround);
					if (got_word.all_done != want_word.all_done)
						report_mismatch("all_done", 32'(got_word.all_done),
							32'(want_word.all_done));
				end
			end
			if (req.valid && req.ready) begin
				schedule_word(req.data, next_word);
				owed_results.push_back(next_word);
			end
			fails   <= fail_cnt;
			pending <= owed_results.size();
		end
	end

endmodule

`default_nettype wire

@@ tb/tb_preemptive_priority_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// tb_preemptive_priority_scheduler_top
// Drives load and tick words into the priority scheduler with random gaps on
// both channels, one long result stall, and a watchdog. A directed opening
// covers ties, preemption, rejects and idle ticks; random traffic follows.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_preemptive_priority_scheduler_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pps_pkg::*;

	localparam int RANDOM_WORDS = 800;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_AFTER   = 200;
	localparam int HOLD_CYCLES  = 300;

	logic clk = 1'b0;
	logic arst_n;
	int   fails;
	int   pending;
	int   ticks_sent  = 0;
	int   loads_taken = 0;
	int   idle_cycles = 0;
	logic steady      = 1'b0;

	always #5ns clk = ~clk;

	pps_req_if req_ch ();
	pps_rsp_if rsp_ch ();

	preemptive_priority_scheduler_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	pps_checker u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.fails   (fails),
		.pending (pending)
	);

	function automatic req_t load_word(input logic [15:0] arr, input logic [15:0] bur,
			input logic [7:0] pri);
		req_t w;
		w.op      = OP_LOAD;
		w.arrival = arr;
		w.burst   = bur;
		w.prio    = pri;
		return w;
	endfunction

	// tick with junk in the unused fields
	function automatic req_t tick_word();
		req_t w;
		w.op      = OP_TICK;
		w.arrival = 16'($urandom);
		w.burst   = 16'($urandom);
		w.prio    = 8'($urandom);
		return w;
	endfunction

	// mostly ticks; loads arrive near the current clock with modest bursts
	function automatic req_t random_word(input int idx);
		req_t w;
		int   arr;
		int   odds;
		w    = tick_word();
		odds = (idx < 600) ? 15 : 3;
		if ($urandom_range(0, odds) == 0) begin
			w.op = OP_LOAD;
			if (loads_taken < MAX_TASKS) begin
				arr = ticks_sent + int'($urandom_range(0, 12)) - 3;
				if (arr < 0)
					arr = 0;
				w.arrival = 16'(arr);
				w.burst   = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 24));
				w.prio    = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) :
					8'($urandom_range(0, 255));
			end
		end
		return w;
	endfunction

	// offer one word and hold it until the block takes it
	task automatic send_word(input req_t w);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.data  <= w;
		req_ch.valid <= 1'b1;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (w.op == OP_TICK)
			ticks_sent++;
		else if (w.burst != 16'd0 && loads_taken < MAX_TASKS)
			loads_taken++;
	endtask

	// reset and stimulus
	initial begin
		arst_n        = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tick on an empty table, then zero-burst rejects
		send_word(tick_word());
		send_word(load_word(16'hFFFF, 16'd0, 8'hFF));
		send_word(load_word(16'd0, 16'd0, 8'd0));
		// equal priority and arrival, lowest id wins; a later top-priority task preempts
		send_word(load_word(16'd0, 16'd4, 8'd5));
		send_word(load_word(16'd0, 16'd2, 8'd5));
		send_word(load_word(16'd3, 16'd1, 8'd255));
		repeat (8) send_word(tick_word());
		// equal priority, earlier arrival wins over lower id
		send_word(load_word(16'd5, 16'd1, 8'd7));
		send_word(load_word(16'd4, 16'd1, 8'd7));
		send_word(load_word(16'd20, 16'd1, 8'd0));
		repeat (4) send_word(tick_word());

		// random traffic, with a stretch of back-to-back words every few hundred
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			steady = ((i / 100) % 3) == 1;
			send_word(random_word(i));
		end
		steady        = 1'b0;
		req_ch.valid <= 1'b0;

		// drain
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("PASS preemptive_priority_scheduler_top");
		else
			$display("FAIL preemptive_priority_scheduler_top");
		$finish;
	end

	// result side: random stalls plus one long hold-off
	initial begin
		int gap;
		int taken;
		taken         = 0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken == HOLD_AFTER)
				gap = HOLD_CYCLES;
			else
				gap = steady ? 0 : $urandom_range(0, 4);
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			taken++;
		end
	end

	// watchdog on cycles with no word moving on either channel
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (req_ch.valid && req_ch.ready) ||
				(rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL preemptive_priority_scheduler_top");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

`default_nettype wire
